FILE: rtl/rmdf_pkg.sv
`default_nettype none
package rmdf_pkg;

	localparam int unsigned SENDER_W     = 32;
	localparam int unsigned SESSION_W    = 16;
	localparam int unsigned SEQ_W        = 32;
	localparam int unsigned HASH_W       = 32;
	localparam int unsigned ID_W         = SENDER_W + SESSION_W + SEQ_W;
	localparam int unsigned ID_BYTES     = ID_W / 8;
	localparam int unsigned BYTES_PER_STEP = 2;
	localparam int unsigned HASH_STEPS   = ID_BYTES / BYTES_PER_STEP;
	localparam int unsigned STEP_CNT_W   = $clog2(HASH_STEPS);
	localparam int unsigned HISTORY_DEPTH_DEF = 48;

	localparam logic [HASH_W-1:0] HASH_SEED = 32'd5381;
	localparam logic [HASH_W-1:0] HASH_ZERO_SUB = 32'd1;

	typedef struct packed {
		logic              done;
		logic [HASH_W-1:0] hash;
	} hash_stat_t;

	typedef struct packed {
		logic              shift;
		logic [HASH_W-1:0] query;
	} cell_ctl_t;

	// one djb2 xor round: h * 33 xor byte, wrapping at 32 bits
	function automatic logic [HASH_W-1:0] hash_step(input logic [HASH_W-1:0] h,
			input logic [7:0] b);
		logic [HASH_W-1:0] mul;
		mul = (h << 5) + h;
		hash_step = mul ^ {{(HASH_W-8){1'b0}}, b};
	endfunction

endpackage
`default_nettype wire

FILE: rtl/recent_message_duplicate_filter.sv
// Each item is hashed by the hash unit (two bytes a cycle), then the cells register their
// compares, then the decide state updates the chain and loads the output register, waiting
// there while a stalled result still holds it; the state machine then returns to idle to
// accept the next item. The input is stalled from acceptance until the return to idle.
// The input side may take a new item while a result waits in the output register.
// Reset (arst_n, asynchronous, active low) clears all cell valid bits at once; no clearing pass.
`default_nettype none
module recent_message_duplicate_filter #(
	parameter int unsigned HISTORY_DEPTH = rmdf_pkg::HISTORY_DEPTH_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	output logic                                 in_stall,
	input  wire logic [rmdf_pkg::SENDER_W-1:0]   node_id,
	input  wire logic [rmdf_pkg::SESSION_W-1:0]  conv_id,
	input  wire logic [rmdf_pkg::SEQ_W-1:0]      sequence_number,
	output logic                                 out_valid,
	input  wire logic                            out_stall,
	output logic                                 is_repeat,
	output logic [rmdf_pkg::HASH_W-1:0]          message_hash
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_HASH,
		ST_DECIDE
	} state_t;

	state_t                      state_q;
	logic                        out_valid_q;
	logic                        is_repeat_q;
	logic [rmdf_pkg::HASH_W-1:0] message_hash_q;

	rmdf_pkg::hash_stat_t        hstat;
	rmdf_pkg::cell_ctl_t         cctl;
	logic                        start;
	logic                        any_hit;
	logic                        out_free;

	logic                        valid_chain [HISTORY_DEPTH+1];
	logic [rmdf_pkg::HASH_W-1:0] entry_chain [HISTORY_DEPTH+1];
	logic [HISTORY_DEPTH-1:0]    hits;

	assign start    = in_valid && (state_q == ST_IDLE);
	assign in_stall = (state_q != ST_IDLE);
	assign out_free = !out_valid_q || !out_stall;
	assign any_hit  = |hits;

	assign cctl.shift = (state_q == ST_DECIDE) && out_free && !any_hit;
	assign cctl.query = hstat.hash;

	rmdf_hash u_hash (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.node_id         (node_id),
		.conv_id         (conv_id),
		.sequence_number (sequence_number),
		.stat            (hstat)
	);

	// newest hash enters at the head of the chain
	assign valid_chain[0] = 1'b1;
	assign entry_chain[0] = hstat.hash;

	for (genvar i = 0; i < HISTORY_DEPTH; i++) begin : g_cell
		rmdf_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctl         (cctl),
			.prev_valid  (valid_chain[i]),
			.prev_entry  (entry_chain[i]),
			.entry_valid (valid_chain[i+1]),
			.entry       (entry_chain[i+1]),
			.hit         (hits[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_HASH;
					end
				end
				ST_HASH: begin
					// cell compares register at this edge against the final hash
					if (hstat.done) begin
						state_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DECIDE && out_free) begin
			is_repeat_q    <= any_hit;
			message_hash_q <= hstat.hash;
		end
	end

	assign out_valid    = out_valid_q;
	assign is_repeat    = is_repeat_q;
	assign message_hash = message_hash_q;

endmodule
`default_nettype wire

FILE: rtl/rmdf_hash.sv
`default_nettype none
module rmdf_hash (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            start,
	input  wire logic [rmdf_pkg::SENDER_W-1:0]   node_id,
	input  wire logic [rmdf_pkg::SESSION_W-1:0]  conv_id,
	input  wire logic [rmdf_pkg::SEQ_W-1:0]      sequence_number,
	output rmdf_pkg::hash_stat_t                 stat
);

	logic [rmdf_pkg::ID_W-1:0]       bytes_q;
	logic [rmdf_pkg::HASH_W-1:0]     h_q;
	logic [rmdf_pkg::HASH_W-1:0]     h_next;
	logic [rmdf_pkg::STEP_CNT_W-1:0] cnt_q;
	logic                            busy_q;
	logic                            done_q;

	// two bytes per cycle, lowest byte first
	always_comb begin
		h_next = rmdf_pkg::hash_step(rmdf_pkg::hash_step(h_q, bytes_q[7:0]), bytes_q[15:8]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == rmdf_pkg::STEP_CNT_W'(rmdf_pkg::HASH_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			bytes_q <= {sequence_number, conv_id, node_id};
			h_q     <= rmdf_pkg::HASH_SEED;
		end else if (busy_q) begin
			bytes_q <= bytes_q >> 16;
			// a zero hash is reserved for empty entries
			if (cnt_q == rmdf_pkg::STEP_CNT_W'(rmdf_pkg::HASH_STEPS - 1) && h_next == '0) begin
				h_q <= rmdf_pkg::HASH_ZERO_SUB;
			end else begin
				h_q <= h_next;
			end
		end
	end

	assign stat.done = done_q;
	assign stat.hash = h_q;

endmodule
`default_nettype wire

FILE: rtl/rmdf_cell.sv
`default_nettype none
module rmdf_cell (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire rmdf_pkg::cell_ctl_t          ctl,
	input  wire logic                         prev_valid,
	input  wire logic [rmdf_pkg::HASH_W-1:0]  prev_entry,
	output logic                              entry_valid,
	output logic [rmdf_pkg::HASH_W-1:0]       entry,
	output logic                              hit
);

	logic                        valid_q;
	logic [rmdf_pkg::HASH_W-1:0] entry_q;
	logic                        hit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			hit_q   <= 1'b0;
		end else begin
			if (ctl.shift) begin
				valid_q <= prev_valid;
			end
			hit_q <= valid_q && (entry_q == ctl.query);
		end
	end

	// take the neighbor's entry on insert; the oldest falls off the far end
	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			entry_q <= prev_entry;
		end
	end

	assign entry_valid = valid_q;
	assign entry       = entry_q;
	assign hit         = hit_q;

endmodule
`default_nettype wire

FILE: rtl/rmdf_checker.sv
`default_nettype none
module rmdf_checker (
	input wire logic                            clk,
	input wire logic                            arst_n,
	input wire logic                            in_valid,
	input wire logic                            in_stall,
	input wire logic                            out_valid,
	input wire logic                            out_stall,
	input wire logic                            is_repeat,
	input wire logic [rmdf_pkg::HASH_W-1:0]     message_hash
);

	// a waiting result holds until taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(message_hash) && $stable(is_repeat))
		else $error("result changed while stalled");

	// zero is reserved for empty entries and never reported
	a_hash_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> message_hash != '0)
		else $error("zero hash reported");

	// one item at a time: the state machine keeps the input stalled
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall ##1 in_stall ##1 in_stall ##1 in_stall)
		else $error("input taken while hashing");

	// no result can appear within the hash time of an accepted item
	a_no_early_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && !out_valid |=> !out_valid ##1 !out_valid)
		else $error("result appeared too early");

endmodule

bind recent_message_duplicate_filter rmdf_checker u_rmdf_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_stall     (in_stall),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.is_repeat    (is_repeat),
	.message_hash (message_hash)
);
`default_nettype wire

FILE: tb/sv/recent_message_duplicate_filter_test.sv
`default_nettype none
module recent_message_duplicate_filter_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned STORE_DEPTH = rmdf_pkg::HISTORY_DEPTH_DEF;
	localparam int unsigned RANDOM_ITEMS = 750;
	localparam int unsigned LONG_HOLD = 300;
	localparam int unsigned RECENT_KEEP = 80;

	typedef logic [rmdf_pkg::HASH_W-1:0] hash_t;

	// byte k of the hashed identity sits at bits [8k +: 8]
	typedef struct packed {
		logic [rmdf_pkg::SEQ_W-1:0]     seq;
		logic [rmdf_pkg::SESSION_W-1:0] session;
		logic [rmdf_pkg::SENDER_W-1:0]  sender;
	} identity_t;

	typedef struct packed {
		logic  is_repeat;
		hash_t hash;
	} verdict_t;

	typedef enum logic [1:0] {BY_MODEL, KNOWN_NEW, KNOWN_REPEAT} verdict_src_t;
	typedef enum logic {ROW_SINGLE, ROW_COLLIDING_PAIR} row_kind_t;

	typedef struct packed {
		row_kind_t    kind;
		verdict_src_t src;
		identity_t    id;
	} row_t;

	localparam hash_t DJB2_START = 32'd5381;
	localparam int unsigned ID_BYTE_COUNT = $bits(identity_t) / 8;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid;
	logic in_stall;
	logic [rmdf_pkg::SENDER_W-1:0] node_id;
	logic [rmdf_pkg::SESSION_W-1:0] conv_id;
	logic [rmdf_pkg::SEQ_W-1:0] sequence_number;
	logic out_valid;
	logic out_stall;
	logic is_repeat;
	hash_t message_hash;

	verdict_src_t verdict_src;
	logic took_item = 1'b0;
	logic long_hold_req = 1'b0;
	int unsigned sender_calm_left = 0;
	int unsigned items_sent = 0;
	int unsigned errors = 0;

	hash_t recent_hashes [STORE_DEPTH] = '{default: '0};
	int unsigned next_slot = 0;
	verdict_t pending_verdicts [$];
	identity_t recent_ids [$];

	// identity is {sequence, session, sender}
	localparam int unsigned DIRECTED_COUNT = 18;
	row_t directed_rows [DIRECTED_COUNT] = '{
		'{ROW_SINGLE, KNOWN_NEW,    {32'h0000_0000, 16'h0000, 32'h0000_0000}},
		'{ROW_SINGLE, KNOWN_REPEAT, {32'h0000_0000, 16'h0000, 32'h0000_0000}},
		'{ROW_SINGLE, BY_MODEL,     {32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF}},
		'{ROW_SINGLE, KNOWN_REPEAT, {32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF}},
		'{ROW_SINGLE, BY_MODEL,     {32'h0000_0000, 16'h0000, 32'hFFFF_FFFF}},
		'{ROW_SINGLE, BY_MODEL,     {32'h0000_0000, 16'hFFFF, 32'h0000_0000}},
		'{ROW_SINGLE, BY_MODEL,     {32'hFFFF_FFFF, 16'h0000, 32'h0000_0000}},
		'{ROW_SINGLE, BY_MODEL,     {32'h0000_0000, 16'h0000, 32'h0000_0001}},
		'{ROW_SINGLE, BY_MODEL,     {32'h0000_0000, 16'h0001, 32'h0000_0000}},
		'{ROW_SINGLE, BY_MODEL,     {32'h0000_0001, 16'h0000, 32'h0000_0000}},
		'{ROW_SINGLE, BY_MODEL,     {32'h8000_0000, 16'h8000, 32'h8000_0000}},
		'{ROW_SINGLE, BY_MODEL,     {32'hAAAA_AAAA, 16'h5555, 32'hAAAA_AAAA}},
		'{ROW_SINGLE, BY_MODEL,     {32'h5555_5555, 16'hAAAA, 32'h5555_5555}},
		'{ROW_SINGLE, KNOWN_REPEAT, {32'h0000_0000, 16'h0000, 32'h0000_0000}},
		'{ROW_COLLIDING_PAIR, BY_MODEL, {32'h0000_1234, 16'hBEEF, 32'h1234_5678}},
		'{ROW_SINGLE, BY_MODEL,     {32'h0000_1235, 16'hBEEF, 32'h1234_5678}},
		'{ROW_SINGLE, BY_MODEL,     {32'hFFFF_0000, 16'h0001, 32'hDEAD_BEEF}},
		'{ROW_SINGLE, KNOWN_REPEAT, {32'hFFFF_0000, 16'h0001, 32'hDEAD_BEEF}}
	};

	recent_message_duplicate_filter dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.node_id(node_id),
		.conv_id(conv_id),
		.sequence_number(sequence_number),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.is_repeat(is_repeat),
		.message_hash(message_hash)
	);

	always #1 clk = ~clk;

	function automatic hash_t djb2_over(identity_t id, int unsigned nbytes);
		hash_t h;
		h = DJB2_START;
		for (int unsigned k = 0; k < nbytes; k++)
			h = (h * 33) ^ hash_t'(id[8*k +: 8]);
		return h;
	endfunction

	function automatic hash_t identity_hash(identity_t id);
		hash_t h;
		h = djb2_over(id, ID_BYTE_COUNT);
		return (h == '0) ? hash_t'(1) : h;
	endfunction

	// look up the hash, and store it at the oldest slot when it is new
	function automatic verdict_t judge_identity(identity_t id);
		verdict_t v;
		v.hash = identity_hash(id);
		v.is_repeat = 1'b0;
		foreach (recent_hashes[i])
			if (recent_hashes[i] == v.hash)
				v.is_repeat = 1'b1;
		if (!v.is_repeat) begin
			recent_hashes[next_slot] = v.hash;
			next_slot = (next_slot == STORE_DEPTH - 1) ? 0 : next_slot + 1;
		end
		return v;
	endfunction

	// Two identities that differ in the top two sequence bytes but hash the same:
	// pick byte 8 so that flipping its low bit moves h*33 only in the low byte,
	// then absorb that difference in byte 9.
	function automatic void build_colliding_pair(input identity_t base,
			output identity_t a, output identity_t b);
		hash_t mid, h9a, h9b, diff;
		logic found;
		mid = djb2_over(base, 8) * 33;
		a = base;
		b = base;
		found = 1'b0;
		for (int v = 0; v < 256; v++) begin
			h9a = mid ^ hash_t'(v);
			h9b = mid ^ hash_t'(v ^ 1);
			diff = (h9a * 33) ^ (h9b * 33);
			if (!found && diff[31:8] == '0) begin
				found = 1'b1;
				a.seq[23:16] = v[7:0];
				b.seq[23:16] = v[7:0] ^ 8'h01;
				b.seq[31:24] = base.seq[31:24] ^ diff[7:0];
			end
		end
	endfunction

	function automatic int unsigned idle_length();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic int unsigned sender_gap();
		if (sender_calm_left != 0) begin
			sender_calm_left--;
			return 0;
		end
		if ($urandom_range(0, 49) == 0)
			sender_calm_left = 30;
		return idle_length();
	endfunction

	function automatic logic [31:0] pick_word();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			default: return $urandom;
		endcase
	endfunction

	// called at a falling edge; returns at the falling edge after the item is taken
	task automatic offer(input identity_t id, input verdict_src_t src);
		int unsigned gap;
		gap = sender_gap();
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		node_id <= id.sender;
		conv_id <= id.session;
		sequence_number <= id.seq;
		verdict_src <= src;
		@(negedge clk);
		while (!took_item)
			@(negedge clk);
		recent_ids.push_back(id);
		if (recent_ids.size() > RECENT_KEEP)
			void'(recent_ids.pop_front());
		items_sent++;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		do
			@(negedge clk);
		while (pending_verdicts.size() != 0);
	endtask

	always @(posedge clk) begin : watch
		verdict_t want;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				want = judge_identity({sequence_number, conv_id, node_id});
				if (verdict_src == KNOWN_NEW)
					want.is_repeat = 1'b0;
				else if (verdict_src == KNOWN_REPEAT)
					want.is_repeat = 1'b1;
				pending_verdicts.push_back(want);
			end
			if (out_valid && !out_stall) begin
				if (pending_verdicts.size() == 0) begin
					$error("unexpected result: is_repeat=%0b message_hash=%h",
						is_repeat, message_hash);
					errors++;
				end else begin
					want = pending_verdicts.pop_front();
					if (is_repeat !== want.is_repeat) begin
						$error("is_repeat: expected %0b, got %0b", want.is_repeat, is_repeat);
						errors++;
					end
					if (message_hash !== want.hash) begin
						$error("message_hash: expected %h, got %h", want.hash, message_hash);
						errors++;
					end
				end
			end
		end
		took_item <= arst_n && in_valid && !in_stall;
	end

	initial begin : receiver
		int unsigned n;
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			if (long_hold_req) begin
				n = LONG_HOLD;
				long_hold_req = 1'b0;
			end else begin
				n = idle_length();
			end
			if (n != 0) begin
				out_stall <= 1'b1;
				repeat (n) @(negedge clk);
			end
			out_stall <= 1'b0;
			repeat (($urandom_range(0, 9) == 0) ? 60 : $urandom_range(1, 6)) @(negedge clk);
		end
	end

	initial begin : limit
		#2_000_000;
		$display("recent_message_duplicate_filter_test failed");
		$finish;
	end

	initial begin : stimulus
		row_t row;
		identity_t id, twin_a, twin_b;
		int unsigned r;
		int unsigned round;
		in_valid = 1'b0;
		node_id = '0;
		conv_id = '0;
		sequence_number = '0;
		verdict_src = BY_MODEL;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed_rows[n]) begin
			row = directed_rows[n];
			if (row.kind == ROW_COLLIDING_PAIR) begin
				build_colliding_pair(row.id, twin_a, twin_b);
				offer(twin_a, row.src);
				offer(twin_b, KNOWN_REPEAT);
			end else begin
				offer(row.id, row.src);
			end
		end

		round = 0;
		while (items_sent < DIRECTED_COUNT + 1 + RANDOM_ITEMS) begin
			if (round == 250) begin
				// hold the output long enough to back up the input side
				long_hold_req = 1'b1;
				sender_calm_left = 40;
			end
			if (round == 500)
				drain();
			r = $urandom_range(0, 99);
			if (r < 40) begin
				id = recent_ids[$urandom_range(0, recent_ids.size() - 1)];
				offer(id, BY_MODEL);
			end else if (r < 55) begin
				// next message of a recent stream
				id = recent_ids[recent_ids.size() - 1];
				id.seq = id.seq + 1;
				offer(id, BY_MODEL);
			end else if (r < 62) begin
				id.sender = $urandom;
				id.session = 16'($urandom_range(0, 65535));
				id.seq = $urandom;
				build_colliding_pair(id, twin_a, twin_b);
				offer(twin_a, BY_MODEL);
				offer(twin_b, BY_MODEL);
			end else begin
				id.sender = pick_word();
				id.session = ($urandom_range(0, 9) == 0) ? '1 : 16'($urandom_range(0, 65535));
				id.seq = pick_word();
				offer(id, BY_MODEL);
			end
			round++;
		end

		in_valid <= 1'b0;
		while (pending_verdicts.size() != 0)
			@(negedge clk);
		repeat (12) @(negedge clk);
		if (errors == 0)
			$display("recent_message_duplicate_filter_test passed");
		else
			$display("recent_message_duplicate_filter_test failed");
		$finish;
	end

endmodule
`default_nettype wire
